[rtl/core/kcmm_pkg.sv]
// kcmm_pkg: shared types and constants of the key count min/max tracker.
// No dependencies; used by kcmm_cell and key_count_min_max_tracker.
`timescale 1ns / 1ps

package kcmm_pkg;

  localparam int KEY_PORT_W = 32;
  localparam int STAMP_W    = 64;

  localparam logic ACT_INC = 1'b0;
  localparam logic ACT_DEC = 1'b1;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_SAT    = 2'd2;
  localparam logic [1:0] STAT_ABSENT = 2'd3;

  // Broadcast command from the sequencer to every cell.
  typedef struct packed {
    logic lookup;
    logic action;
  } kcmm_cmd_t;

  // Per-cell report back to the sequencer.
  typedef struct packed {
    logic valid;
    logic match;
    logic sat;
    logic gone;
  } kcmm_rep_t;

  // Control part of the scan wave passed cell to cell.
  typedef struct packed {
    logic active;
    logic ins;
    logic max_vld;
    logic min_vld;
  } kcmm_wctl_t;

endpackage

[rtl/core/kcmm_cell.sv]
// kcmm_cell: one table entry (valid, key, count, stamp) plus one stage of the
// scan wave that claims a free entry and carries the running max/min.
// Depends on kcmm_pkg.
`timescale 1ns / 1ps

module kcmm_cell #(
  parameter int KW = 32,
  parameter int CW = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kcmm_pkg::kcmm_cmd_t            cmd,
  input  logic [KW-1:0]                  cmd_key,
  input  logic [kcmm_pkg::STAMP_W-1:0]   cmd_stamp,
  output kcmm_pkg::kcmm_rep_t            rep,
  input  kcmm_pkg::kcmm_wctl_t           w_ctl_in,
  input  logic [CW-1:0]                  w_max_cnt_in,
  input  logic [kcmm_pkg::STAMP_W-1:0]   w_max_stamp_in,
  input  logic [KW-1:0]                  w_max_key_in,
  input  logic [CW-1:0]                  w_min_cnt_in,
  input  logic [kcmm_pkg::STAMP_W-1:0]   w_min_stamp_in,
  input  logic [KW-1:0]                  w_min_key_in,
  output kcmm_pkg::kcmm_wctl_t           w_ctl_out,
  output logic [CW-1:0]                  w_max_cnt_out,
  output logic [kcmm_pkg::STAMP_W-1:0]   w_max_stamp_out,
  output logic [KW-1:0]                  w_max_key_out,
  output logic [CW-1:0]                  w_min_cnt_out,
  output logic [kcmm_pkg::STAMP_W-1:0]   w_min_stamp_out,
  output logic [KW-1:0]                  w_min_key_out
);

  logic                         valid_r, valid_nxt;
  logic [KW-1:0]                key_r, key_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [kcmm_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;

  kcmm_pkg::kcmm_wctl_t         wctl_r, wctl_nxt;
  logic [CW-1:0]                max_cnt_r, max_cnt_nxt, min_cnt_r, min_cnt_nxt;
  logic [kcmm_pkg::STAMP_W-1:0] max_stamp_r, max_stamp_nxt, min_stamp_r, min_stamp_nxt;
  logic [KW-1:0]                max_key_r, max_key_nxt, min_key_r, min_key_nxt;

  logic                         match, sat, gone, claim;
  logic                         eff_valid, take_max, take_min;
  logic [KW-1:0]                eff_key;
  logic [CW-1:0]                eff_count;
  logic [kcmm_pkg::STAMP_W-1:0] eff_stamp;

  assign match = valid_r && (key_r == cmd_key);
  assign sat   = &count_r;
  assign gone  = (count_r <= CW'(1));
  assign claim = w_ctl_in.active && w_ctl_in.ins && !valid_r;

  assign rep.valid = valid_r;
  assign rep.match = match;
  assign rep.sat   = match && sat;
  assign rep.gone  = match && gone;

  // entry update: hit update during lookup, free-entry claim during scan
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    stamp_nxt = stamp_r;
    if (cmd.lookup && match) begin
      if (cmd.action == kcmm_pkg::ACT_INC) begin
        if (!sat) begin
          count_nxt = count_r + CW'(1);
          stamp_nxt = cmd_stamp;
        end
      end else if (gone) begin
        valid_nxt = 1'b0;
      end else begin
        count_nxt = count_r - CW'(1);
        stamp_nxt = cmd_stamp;
      end
    end else if (claim) begin
      valid_nxt = 1'b1;
      key_nxt   = cmd_key;
      count_nxt = CW'(1);
      stamp_nxt = cmd_stamp;
    end
  end

  // values seen by the wave, including a claim made in this cycle
  assign eff_valid = valid_r | claim;
  assign eff_key   = claim ? cmd_key   : key_r;
  assign eff_count = claim ? CW'(1)    : count_r;
  assign eff_stamp = claim ? cmd_stamp : stamp_r;

  assign take_max = eff_valid && (!w_ctl_in.max_vld || (eff_count > w_max_cnt_in) ||
                    ((eff_count == w_max_cnt_in) && (eff_stamp > w_max_stamp_in)));
  assign take_min = eff_valid && (!w_ctl_in.min_vld || (eff_count < w_min_cnt_in) ||
                    ((eff_count == w_min_cnt_in) && (eff_stamp > w_min_stamp_in)));

  always_comb begin
    wctl_nxt.active  = w_ctl_in.active;
    wctl_nxt.ins     = w_ctl_in.ins && !claim;
    wctl_nxt.max_vld = w_ctl_in.max_vld || take_max;
    wctl_nxt.min_vld = w_ctl_in.min_vld || take_min;
    max_cnt_nxt      = take_max ? eff_count : w_max_cnt_in;
    max_stamp_nxt    = take_max ? eff_stamp : w_max_stamp_in;
    max_key_nxt      = take_max ? eff_key   : w_max_key_in;
    min_cnt_nxt      = take_min ? eff_count : w_min_cnt_in;
    min_stamp_nxt    = take_min ? eff_stamp : w_min_stamp_in;
    min_key_nxt      = take_min ? eff_key   : w_min_key_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wctl_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      wctl_r  <= wctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    count_r     <= count_nxt;
    stamp_r     <= stamp_nxt;
    max_cnt_r   <= max_cnt_nxt;
    max_stamp_r <= max_stamp_nxt;
    max_key_r   <= max_key_nxt;
    min_cnt_r   <= min_cnt_nxt;
    min_stamp_r <= min_stamp_nxt;
    min_key_r   <= min_key_nxt;
  end

  assign w_ctl_out       = wctl_r;
  assign w_max_cnt_out   = max_cnt_r;
  assign w_max_stamp_out = max_stamp_r;
  assign w_max_key_out   = max_key_r;
  assign w_min_cnt_out   = min_cnt_r;
  assign w_min_stamp_out = min_stamp_r;
  assign w_min_key_out   = min_key_r;

endmodule

[rtl/core/key_count_min_max_tracker.sv]
// key_count_min_max_tracker: keyed counter table with max/min count report.
// Depends on kcmm_pkg and kcmm_cell (one cell per table entry).
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid, in_ready, in_action, in_key            | in
//   out     | out_valid, out_ready, out_max_key, out_min_key,  | out
//           | out_is_empty, out_status                         |
//
// A transaction runs in order: accept, broadcast lookup/update, then the
// scan wave crosses the cell chain one cell per cycle, then the
// result is moved into the output register.
// Reset clears entry valids and the stamp counter.
// The result waits in the output register while the next transaction is
// accepted; a finished scan holds until that register is free.
`timescale 1ns / 1ps

module key_count_min_max_tracker #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [kcmm_pkg::KEY_PORT_W-1:0]   in_key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kcmm_pkg::KEY_PORT_W-1:0]   out_max_key,
  output logic [kcmm_pkg::KEY_PORT_W-1:0]   out_min_key,
  output logic                              out_is_empty,
  output logic [1:0]                        out_status
);

  localparam int KW = (KEY_BITS < kcmm_pkg::KEY_PORT_W) ? KEY_BITS : kcmm_pkg::KEY_PORT_W;
  localparam int CW = COUNT_BITS;
  localparam int SW = kcmm_pkg::STAMP_W;
  localparam int PW = kcmm_pkg::KEY_PORT_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic              action_r, action_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [SW-1:0]     op_stamp_r, op_stamp_nxt;
  logic [SW-1:0]     stamp_cnt_r, stamp_cnt_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              launch_r, launch_nxt;
  logic              ins_r, ins_nxt;
  logic [PW-1:0]     res_max_r, res_max_nxt, res_min_r, res_min_nxt;
  logic              res_empty_r, res_empty_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PW-1:0]     out_max_r, out_max_nxt, out_min_r, out_min_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  kcmm_pkg::kcmm_cmd_t  cmd;
  kcmm_pkg::kcmm_rep_t  rep [0:ENTRIES-1];
  logic [ENTRIES-1:0]   valid_vec, match_vec, sat_vec, gone_vec;
  logic                 hit, sat_hit, gone_hit, free_any, change, out_free;

  kcmm_pkg::kcmm_wctl_t w_ctl [0:ENTRIES];
  logic [CW-1:0]        w_max_cnt [0:ENTRIES];
  logic [SW-1:0]        w_max_stamp [0:ENTRIES];
  logic [KW-1:0]        w_max_key [0:ENTRIES];
  logic [CW-1:0]        w_min_cnt [0:ENTRIES];
  logic [SW-1:0]        w_min_stamp [0:ENTRIES];
  logic [KW-1:0]        w_min_key [0:ENTRIES];

  assign cmd.lookup = (state_r == ST_LOOKUP);
  assign cmd.action = action_r;

  assign w_ctl[0].active  = launch_r;
  assign w_ctl[0].ins     = ins_r;
  assign w_ctl[0].max_vld = 1'b0;
  assign w_ctl[0].min_vld = 1'b0;
  assign w_max_cnt[0]     = '0;
  assign w_max_stamp[0]   = '0;
  assign w_max_key[0]     = '0;
  assign w_min_cnt[0]     = '0;
  assign w_min_stamp[0]   = '0;
  assign w_min_key[0]     = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    kcmm_cell #(
      .KW (KW),
      .CW (CW)
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .cmd             (cmd),
      .cmd_key         (key_r),
      .cmd_stamp       (op_stamp_r),
      .rep             (rep[g]),
      .w_ctl_in        (w_ctl[g]),
      .w_max_cnt_in    (w_max_cnt[g]),
      .w_max_stamp_in  (w_max_stamp[g]),
      .w_max_key_in    (w_max_key[g]),
      .w_min_cnt_in    (w_min_cnt[g]),
      .w_min_stamp_in  (w_min_stamp[g]),
      .w_min_key_in    (w_min_key[g]),
      .w_ctl_out       (w_ctl[g+1]),
      .w_max_cnt_out   (w_max_cnt[g+1]),
      .w_max_stamp_out (w_max_stamp[g+1]),
      .w_max_key_out   (w_max_key[g+1]),
      .w_min_cnt_out   (w_min_cnt[g+1]),
      .w_min_stamp_out (w_min_stamp[g+1]),
      .w_min_key_out   (w_min_key[g+1])
    );
    assign valid_vec[g] = rep[g].valid;
    assign match_vec[g] = rep[g].match;
    assign sat_vec[g]   = rep[g].sat;
    assign gone_vec[g]  = rep[g].gone;
  end

  assign hit      = |match_vec;
  assign sat_hit  = |sat_vec;
  assign gone_hit = |gone_vec;
  assign free_any = ~&valid_vec;
  assign change   = (action_r == kcmm_pkg::ACT_INC) ? (hit ? !sat_hit : free_any)
                                                    : (hit && !gone_hit);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    op_stamp_nxt   = op_stamp_r;
    stamp_cnt_nxt  = stamp_cnt_r;
    status_nxt     = status_r;
    launch_nxt     = 1'b0;
    ins_nxt        = ins_r;
    res_max_nxt    = res_max_r;
    res_min_nxt    = res_min_r;
    res_empty_nxt  = res_empty_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_max_nxt    = out_max_r;
    out_min_nxt    = out_min_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          action_nxt   = in_action;
          key_nxt      = in_key[KW-1:0];
          op_stamp_nxt = stamp_cnt_r;
          state_nxt    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (action_r == kcmm_pkg::ACT_INC) begin
          status_nxt = hit ? (sat_hit ? kcmm_pkg::STAT_SAT : kcmm_pkg::STAT_DONE)
                           : (free_any ? kcmm_pkg::STAT_DONE : kcmm_pkg::STAT_FULL);
        end else begin
          status_nxt = hit ? kcmm_pkg::STAT_DONE : kcmm_pkg::STAT_ABSENT;
        end
        ins_nxt       = (action_r == kcmm_pkg::ACT_INC) && !hit && free_any;
        stamp_cnt_nxt = change ? stamp_cnt_r + SW'(1) : stamp_cnt_r;
        launch_nxt    = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        if (w_ctl[ENTRIES].active) begin
          res_empty_nxt = !w_ctl[ENTRIES].max_vld;
          res_max_nxt   = w_ctl[ENTRIES].max_vld ? PW'(w_max_key[ENTRIES]) : '0;
          res_min_nxt   = w_ctl[ENTRIES].min_vld ? PW'(w_min_key[ENTRIES]) : '0;
          state_nxt     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_max_nxt    = res_max_r;
          out_min_nxt    = res_min_r;
          out_empty_nxt  = res_empty_r;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stamp_cnt_r <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    op_stamp_r   <= op_stamp_nxt;
    status_r     <= status_nxt;
    ins_r        <= ins_nxt;
    res_max_r    <= res_max_nxt;
    res_min_r    <= res_min_nxt;
    res_empty_r  <= res_empty_nxt;
    out_max_r    <= out_max_nxt;
    out_min_r    <= out_min_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_max_key  = out_max_r;
  assign out_min_key  = out_min_r;
  assign out_is_empty = out_empty_r;
  assign out_status   = out_status_r;

endmodule
